@@ rtl/ctc_pkg.sv @@
// Package: shared types, op codes and verdict codes for the container trace classifier.
`default_nettype none
package ctc_pkg;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        VERDICT_IMPOSSIBLE = 3'd0,
        VERDICT_NOT_SURE   = 3'd1,
        VERDICT_STACK      = 3'd2,
        VERDICT_QUEUE      = 3'd3,
        VERDICT_PRIORITY   = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [1:0]  op;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] verdict;
        logic       overflow;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CHK,
        ST_HPUSH_RD,
        ST_HPUSH_CMP,
        ST_HPOP_LAST,
        ST_HPOP_LAST_W,
        ST_HPOP_RDL,
        ST_HPOP_RDR,
        ST_HPOP_CMP
    } state_t;

    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

endpackage
`default_nettype wire

@@ rtl/container_trace_classifier.sv @@
// Top level: trace classifier running a stack, a FIFO and a max-heap side by side.
`default_nettype none
// Usage
//   Command channel: drive start with in_item (op, value); the item is taken at
//   a rising edge with start high and busy low. busy stays high while the item
//   is worked on. A finish item produces one result: done pulses for exactly
//   one cycle with out_item (verdict, overflow); the receiver cannot stall it.
//   - push: no sift into an empty or full heap; otherwise the key climbs,
//     reading the parent, comparing and moving the parent down, until it is
//     written where it settles or at the root.
//   - pop: read the three heads, then check them; when the heap is popped
//     with entries left, read the last entry, then per level on the way
//     down: write, left read, right read if there is a right child, compare.
//   - finish: done follows the accepting edge; op 3 is dropped.
//   The heap sift is the limit: a compare unit shared by both sifts and a
//     single heap memory port, one read or write per cycle.
//   Reset: rst_n clears counts, pointers and flags; stores are not cleared,
//   since only entries below each count are ever read. Finish resets the same
//   state for the next trace in the same cycle.
module container_trace_classifier #(
    parameter int DEPTH = 1024
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   start,
    input  wire ctc_pkg::in_item_t in_item,
    output logic                  busy,
    output logic                  done,
    output ctc_pkg::out_item_t    out_item
);
    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    ctc_pkg::state_t state_reg, state_next;

    logic [CW-1:0] stack_count_reg, stack_count_next;
    logic [CW-1:0] fifo_count_reg, fifo_count_next;
    logic [AW-1:0] fifo_head_reg, fifo_head_next;
    logic [AW-1:0] fifo_tail_reg, fifo_tail_next;
    logic [CW-1:0] heap_count_reg, heap_count_next;
    logic stack_ok_reg, stack_ok_next;
    logic fifo_ok_reg, fifo_ok_next;
    logic heap_ok_reg, heap_ok_next;
    logic ovf_reg, ovf_next;
    logic done_reg, done_next;
    ctc_pkg::out_item_t out_reg, out_next;

    logic [31:0] val_reg, val_next;      // popped value, or biased heap key
    logic [31:0] last_reg, last_next;    // element being sifted down
    logic [31:0] lchild_reg, lchild_next;
    logic [CW-1:0] idx_reg, idx_next;    // heap position being sifted

    // larger child during a sift down
    logic [31:0]   big_key;
    logic [CW-1:0] big_idx;

    // memory ports
    logic          s_we, f_we, h_we;
    logic [AW-1:0] s_addr, f_addr, h_addr;
    logic [31:0]   s_wdata, f_wdata, h_wdata;
    logic [31:0]   s_rdata, f_rdata, h_rdata;

    ctc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_stack (
        .clk(clk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata));
    ctc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_fifo (
        .clk(clk), .we(f_we), .addr(f_addr), .wdata(f_wdata), .rdata(f_rdata));
    ctc_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_heap (
        .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wdata), .rdata(h_rdata));

    logic accept;
    assign accept = start && (state_reg == ctc_pkg::ST_IDLE);
    assign busy = (state_reg != ctc_pkg::ST_IDLE);
    assign done = done_reg;
    assign out_item = out_reg;

    // shared compare unit: unsigned compare of biased heap keys
    logic [31:0] cmp_a, cmp_b;
    logic        cmp_gt;
    assign cmp_gt = cmp_a > cmp_b;

    // heap index helpers
    logic [CW-1:0] parent_idx, lchild_idx, rchild_idx;
    assign parent_idx = (idx_reg - CW'(1)) >> 1;
    assign lchild_idx = {idx_reg[CW-2:0], 1'b1};
    assign rchild_idx = lchild_idx + CW'(1);
    logic lchild_in, rchild_in;
    assign lchild_in = ({1'b0, idx_reg} << 1) + (CW+1)'(1) < {1'b0, heap_count_reg};
    assign rchild_in = ({1'b0, idx_reg} << 1) + (CW+1)'(2) < {1'b0, heap_count_reg};

    logic [2:0] n_ok;
    assign n_ok = 3'(stack_ok_reg) + 3'(fifo_ok_reg) + 3'(heap_ok_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ctc_pkg::ST_IDLE;
            stack_count_reg <= '0;
            fifo_count_reg  <= '0;
            fifo_head_reg   <= '0;
            fifo_tail_reg   <= '0;
            heap_count_reg  <= '0;
            stack_ok_reg    <= 1'b1;
            fifo_ok_reg     <= 1'b1;
            heap_ok_reg     <= 1'b1;
            ovf_reg         <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            stack_count_reg <= stack_count_next;
            fifo_count_reg  <= fifo_count_next;
            fifo_head_reg   <= fifo_head_next;
            fifo_tail_reg   <= fifo_tail_next;
            heap_count_reg  <= heap_count_next;
            stack_ok_reg    <= stack_ok_next;
            fifo_ok_reg     <= fifo_ok_next;
            heap_ok_reg     <= heap_ok_next;
            ovf_reg         <= ovf_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
        lchild_reg <= lchild_next;
        idx_reg    <= idx_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (ctc_pkg::op_t'(in_item.op))
                        ctc_pkg::OP_PUSH:
                            state_next = (heap_count_reg < FULL) ?
                                ((heap_count_reg == '0) ? ctc_pkg::ST_IDLE
                                                        : ctc_pkg::ST_HPUSH_RD)
                                : ctc_pkg::ST_IDLE;
                        ctc_pkg::OP_POP: state_next = ctc_pkg::ST_POP_RD;
                        default:         state_next = ctc_pkg::ST_IDLE;
                    endcase
                end
            end
            ctc_pkg::ST_POP_RD:   state_next = ctc_pkg::ST_POP_CHK;
            ctc_pkg::ST_POP_CHK:
            begin
                if (heap_count_reg != '0 && h_rdata == (val_reg ^ ctc_pkg::SIGN_BIAS)
                    && heap_count_reg > CW'(1))
                    state_next = ctc_pkg::ST_HPOP_LAST;
                else
                    state_next = ctc_pkg::ST_IDLE;
            end
            ctc_pkg::ST_HPUSH_RD:
                state_next = (idx_reg == '0) ? ctc_pkg::ST_IDLE : ctc_pkg::ST_HPUSH_CMP;
            ctc_pkg::ST_HPUSH_CMP:
                state_next = cmp_gt ? ctc_pkg::ST_HPUSH_RD : ctc_pkg::ST_IDLE;
            ctc_pkg::ST_HPOP_LAST:   state_next = ctc_pkg::ST_HPOP_LAST_W;
            ctc_pkg::ST_HPOP_LAST_W:
                state_next = lchild_in ? ctc_pkg::ST_HPOP_RDL : ctc_pkg::ST_IDLE;
            ctc_pkg::ST_HPOP_RDL:
                state_next = rchild_in ? ctc_pkg::ST_HPOP_RDR : ctc_pkg::ST_HPOP_CMP;
            ctc_pkg::ST_HPOP_RDR:    state_next = ctc_pkg::ST_HPOP_CMP;
            ctc_pkg::ST_HPOP_CMP:
            begin
                if (cmp_gt)
                    state_next = ctc_pkg::ST_HPOP_LAST_W;
                else
                    state_next = ctc_pkg::ST_IDLE;
            end
            default: state_next = ctc_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        stack_count_next = stack_count_reg;
        fifo_count_next  = fifo_count_reg;
        fifo_head_next   = fifo_head_reg;
        fifo_tail_next   = fifo_tail_reg;
        heap_count_next  = heap_count_reg;
        stack_ok_next    = stack_ok_reg;
        fifo_ok_next     = fifo_ok_reg;
        heap_ok_next     = heap_ok_reg;
        ovf_next         = ovf_reg;
        done_next        = 1'b0;
        out_next         = out_reg;
        val_next         = val_reg;
        last_next        = last_reg;
        lchild_next      = lchild_reg;
        idx_next         = idx_reg;
        big_key          = h_rdata;
        big_idx          = lchild_idx;
        s_we = 1'b0; s_addr = stack_count_reg[AW-1:0]; s_wdata = in_item.value;
        f_we = 1'b0; f_addr = fifo_tail_reg;           f_wdata = in_item.value;
        h_we = 1'b0; h_addr = idx_reg[AW-1:0];         h_wdata = val_reg;
        cmp_a = val_reg;
        cmp_b = h_rdata;

        case (state_reg)
            ctc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (ctc_pkg::op_t'(in_item.op))
                        ctc_pkg::OP_PUSH:
                        begin
                            if (stack_count_reg < FULL)
                            begin
                                s_we = 1'b1;
                                stack_count_next = stack_count_reg + CW'(1);
                            end
                            else
                                ovf_next = 1'b1;
                            if (fifo_count_reg < FULL)
                            begin
                                f_we = 1'b1;
                                fifo_tail_next = (fifo_tail_reg == AW'(DEPTH - 1)) ?
                                                 '0 : fifo_tail_reg + AW'(1);
                                fifo_count_next = fifo_count_reg + CW'(1);
                            end
                            else
                                ovf_next = 1'b1;
                            if (heap_count_reg < FULL)
                            begin
                                // hold the key at the hole and read parent next; an empty heap writes it at the root
                                val_next = in_item.value ^ ctc_pkg::SIGN_BIAS;
                                idx_next = heap_count_reg;
                                heap_count_next = heap_count_reg + CW'(1);
                                if (heap_count_reg == '0)
                                begin
                                    h_we = 1'b1;
                                    h_addr = '0;
                                    h_wdata = in_item.value ^ ctc_pkg::SIGN_BIAS;
                                end
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        ctc_pkg::OP_POP:
                            val_next = in_item.value;
                        ctc_pkg::OP_FINISH:
                        begin
                            done_next = 1'b1;
                            out_next.overflow = ovf_reg;
                            if (n_ok == 3'd0)
                                out_next.verdict = ctc_pkg::VERDICT_IMPOSSIBLE;
                            else if (n_ok > 3'd1)
                                out_next.verdict = ctc_pkg::VERDICT_NOT_SURE;
                            else if (stack_ok_reg)
                                out_next.verdict = ctc_pkg::VERDICT_STACK;
                            else if (fifo_ok_reg)
                                out_next.verdict = ctc_pkg::VERDICT_QUEUE;
                            else
                                out_next.verdict = ctc_pkg::VERDICT_PRIORITY;
                            stack_count_next = '0;
                            fifo_count_next  = '0;
                            fifo_head_next   = '0;
                            fifo_tail_next   = '0;
                            heap_count_next  = '0;
                            stack_ok_next    = 1'b1;
                            fifo_ok_next     = 1'b1;
                            heap_ok_next     = 1'b1;
                            ovf_next         = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ctc_pkg::ST_POP_RD:
            begin
                // read the three heads
                s_addr = stack_count_reg[AW-1:0] - AW'(1);
                f_addr = fifo_head_reg;
                h_addr = '0;
            end
            ctc_pkg::ST_POP_CHK:
            begin
                if (stack_count_reg == '0 || s_rdata != val_reg)
                    stack_ok_next = 1'b0;
                else
                    stack_count_next = stack_count_reg - CW'(1);
                if (fifo_count_reg == '0 || f_rdata != val_reg)
                    fifo_ok_next = 1'b0;
                else
                begin
                    fifo_head_next = (fifo_head_reg == AW'(DEPTH - 1)) ?
                                     '0 : fifo_head_reg + AW'(1);
                    fifo_count_next = fifo_count_reg - CW'(1);
                end
                if (heap_count_reg == '0 || h_rdata != (val_reg ^ ctc_pkg::SIGN_BIAS))
                    heap_ok_next = 1'b0;
                else
                begin
                    heap_count_next = heap_count_reg - CW'(1);
                    idx_next = '0;
                end
            end
            ctc_pkg::ST_HPUSH_RD:
            begin
                // key has climbed to the root: drop it there, else read the parent
                if (idx_reg == '0)
                    h_we = 1'b1;
                else
                    h_addr = parent_idx[AW-1:0];
            end
            ctc_pkg::ST_HPUSH_CMP:
            begin
                // key above parent: move parent down and climb, else settle the key
                h_we = 1'b1;
                if (cmp_gt)
                begin
                    h_wdata = h_rdata;
                    idx_next = parent_idx;
                end
                else
                    h_wdata = val_reg;
            end
            ctc_pkg::ST_HPOP_LAST:
                h_addr = heap_count_reg[AW-1:0];
            ctc_pkg::ST_HPOP_LAST_W:
            begin
                // place the sifted element at the hole; the first pass takes it
                // straight from the read of the last entry
                h_we = 1'b1;
                if (idx_reg == '0)
                begin
                    last_next = h_rdata;
                    h_wdata = h_rdata;
                end
                else
                    h_wdata = last_reg;
            end
            ctc_pkg::ST_HPOP_RDL:
                h_addr = lchild_idx[AW-1:0];
            ctc_pkg::ST_HPOP_RDR:
            begin
                h_addr = rchild_idx[AW-1:0];
                lchild_next = h_rdata;
            end
            ctc_pkg::ST_HPOP_CMP:
            begin
                // pick the larger child, then compare with the sifted element
                big_key = rchild_in ? lchild_reg : h_rdata;
                big_idx = lchild_idx;
                if (rchild_in && h_rdata > lchild_reg)
                begin
                    big_key = h_rdata;
                    big_idx = rchild_idx;
                end
                cmp_a = big_key;
                cmp_b = last_reg;
                if (cmp_gt)
                begin
                    h_we = 1'b1;
                    h_wdata = big_key;
                    idx_next = big_idx;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

@@ rtl/ctc_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module ctc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                      clk,
    input  wire                      we,
    input  wire [$clog2(DEPTH)-1:0]  addr,
    input  wire [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
// Testbench for the container trace classifier: driven traces, scoreboard prediction of verdicts.
`default_nettype none
module testbench;

    localparam int DEPTH = 1024;

    // Scoreboard: mirrors stack, FIFO and max-heap, and holds the expected verdicts
    class verdict_board;
        logic signed [31:0] stk [$];
        logic signed [31:0] fq [$];
        logic signed [31:0] hp [$];
        bit stk_ok, fq_ok, hp_ok, ovf;
        ctc_pkg::out_item_t pending [$];
        int errors;

        function new();
            errors = 0;
            clear_trace();
        endfunction

        function void clear_trace();
            stk.delete();
            fq.delete();
            hp.delete();
            stk_ok = 1;
            fq_ok = 1;
            hp_ok = 1;
            ovf = 0;
        endfunction

        // index of the largest heap entry (signed order)
        function int heap_top();
            int m;
            m = 0;
            for (int i = 1; i < hp.size(); i++)
                if (hp[i] > hp[m])
                    m = i;
            return m;
        endfunction

        function void note_item(ctc_pkg::in_item_t it);
            ctc_pkg::out_item_t r;
            int n;
            int m;
            case (ctc_pkg::op_t'(it.op))
                ctc_pkg::OP_PUSH:
                begin
                    if (stk.size() < DEPTH) stk.push_back(it.value); else ovf = 1;
                    if (fq.size() < DEPTH) fq.push_back(it.value); else ovf = 1;
                    if (hp.size() < DEPTH) hp.push_back(it.value); else ovf = 1;
                end
                ctc_pkg::OP_POP:
                begin
                    if (stk.size() == 0 || stk[$] != it.value) stk_ok = 0;
                    else void'(stk.pop_back());
                    if (fq.size() == 0 || fq[0] != it.value) fq_ok = 0;
                    else void'(fq.pop_front());
                    if (hp.size() == 0) hp_ok = 0;
                    else
                    begin
                        m = heap_top();
                        if (hp[m] != it.value) hp_ok = 0;
                        else hp.delete(m);
                    end
                end
                ctc_pkg::OP_FINISH:
                begin
                    n = stk_ok + fq_ok + hp_ok;
                    if (n == 0) r.verdict = ctc_pkg::VERDICT_IMPOSSIBLE;
                    else if (n > 1) r.verdict = ctc_pkg::VERDICT_NOT_SURE;
                    else if (stk_ok) r.verdict = ctc_pkg::VERDICT_STACK;
                    else if (fq_ok) r.verdict = ctc_pkg::VERDICT_QUEUE;
                    else r.verdict = ctc_pkg::VERDICT_PRIORITY;
                    r.overflow = ovf;
                    pending.push_back(r);
                    clear_trace();
                end
                default: ;
            endcase
        endfunction

        function void check_result(ctc_pkg::out_item_t got);
            ctc_pkg::out_item_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result verdict=%0d overflow=%0d", got.verdict, got.overflow);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.verdict !== want.verdict)
            begin
                $error("verdict: expected %0d, actual %0d", want.verdict, got.verdict);
                errors++;
            end
            if (got.overflow !== want.overflow)
            begin
                $error("overflow: expected %0d, actual %0d", want.overflow, got.overflow);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    ctc_pkg::in_item_t in_item = '0;
    logic busy, done;
    ctc_pkg::out_item_t out_item;

    verdict_board board = new();
    int idle_pct = 0;

    // Trace under construction: the values a well-formed stack/FIFO/heap would return
    logic signed [31:0] live [$];

    always #1 clk = ~clk;

    container_trace_classifier #(.DEPTH(DEPTH)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .in_item(in_item),
        .busy(busy), .done(done), .out_item(out_item)
    );

    // Results cannot be held off: sample every strobe at the edge that ends it
    always @(posedge clk)
        if (rst_n && done)
            board.check_result(out_item);

    // Present one item, hold it until taken; idle gaps come before it.
    // start stays high after the item is taken, so the next item follows at
    // once; drop start with stop_driving before any wait outside this task.
    task automatic send(ctc_pkg::op_t op, logic signed [31:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        in_item <= '{op: op, value: v};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item('{op: op, value: v});
    endtask

    task automatic stop_driving();
        start <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(4))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom_range(7) - 3;
            default: return $urandom;
        endcase
    endfunction

    // One trace shaped after a chosen container; some pops are broken on purpose
    task automatic random_trace(output int sent);
        int kind, len, idx;
        logic signed [31:0] v;
        kind = $urandom_range(3);
        len = $urandom_range(12);
        live.delete();
        sent = 0;
        for (int i = 0; i < len; i++)
        begin
            if (live.size() == 0 || $urandom_range(1))
            begin
                v = rand_value();
                live.push_back(v);
                send(ctc_pkg::OP_PUSH, v);
            end
            else
            begin
                idx = 0;
                if (kind == 0) idx = live.size() - 1;
                else if (kind == 2)
                    for (int j = 1; j < live.size(); j++)
                        if (live[j] > live[idx]) idx = j;
                v = live[idx];
                if (kind == 3 || $urandom_range(19) == 0)
                    v = live[$urandom_range(live.size() - 1)];
                if ($urandom_range(29) == 0)
                    v = $urandom;
                else
                    live.delete(idx);
                send(ctc_pkg::OP_POP, v);
            end
            sent++;
            if ($urandom_range(49) == 0)
                send(ctc_pkg::OP_NONE, $urandom);
        end
        send(ctc_pkg::OP_FINISH, $urandom);
        sent++;
    endtask

    initial
    begin
        int sent, total;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty trace, each container alone, extremes, ignored op, empty pop
        send(ctc_pkg::OP_FINISH, 0);
        send(ctc_pkg::OP_PUSH, 32'sh7fffffff);
        send(ctc_pkg::OP_PUSH, 32'sh80000000);
        send(ctc_pkg::OP_PUSH, 1);
        send(ctc_pkg::OP_POP, 1);
        send(ctc_pkg::OP_POP, 32'sh80000000);
        send(ctc_pkg::OP_FINISH, 0);
        send(ctc_pkg::OP_PUSH, -5);
        send(ctc_pkg::OP_PUSH, 3);
        send(ctc_pkg::OP_POP, -5);
        send(ctc_pkg::OP_FINISH, 0);
        send(ctc_pkg::OP_PUSH, 3);
        send(ctc_pkg::OP_PUSH, 9);
        send(ctc_pkg::OP_PUSH, -1);
        send(ctc_pkg::OP_POP, 9);
        send(ctc_pkg::OP_NONE, 32'hffffffff);
        send(ctc_pkg::OP_FINISH, 0);
        send(ctc_pkg::OP_POP, 0);
        send(ctc_pkg::OP_FINISH, 0);
        send(ctc_pkg::OP_PUSH, 4);
        send(ctc_pkg::OP_PUSH, 4);
        send(ctc_pkg::OP_POP, 4);
        send(ctc_pkg::OP_POP, 4);
        send(ctc_pkg::OP_FINISH, 32'hffffffff);

        // Overflow: fill the stores past DEPTH once
        for (int i = 0; i <= DEPTH; i++)
            send(ctc_pkg::OP_PUSH, $urandom);
        send(ctc_pkg::OP_FINISH, 0);

        // Random traces across idling phases
        total = 0;
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 1) ? 66 : (ph == 2) ? 0 : 25;
            while (total < (ph + 1) * 140)
            begin
                random_trace(sent);
                total += sent;
            end
            // Pause until every verdict is back
            stop_driving();
            while (board.pending.size() != 0)
                @(posedge clk);
        end

        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
rtl/ctc_pkg.sv
rtl/ctc_ram.sv
rtl/container_trace_classifier.sv
tb/sv/testbench.sv
